// ===== hw/rtl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg: shared types, constants and functions
// Register indexes, fixed-point constants and the divider pipeline types used
// across the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

   // Register indexes on the configuration port.
   localparam int unsigned VRP_NUM_CSR = 8;
   localparam logic [7:0] CSR_COS_Z   = 8'd0;
   localparam logic [7:0] CSR_SIN_Z   = 8'd1;
   localparam logic [7:0] CSR_COS_X   = 8'd2;
   localparam logic [7:0] CSR_SIN_X   = 8'd3;
   localparam logic [7:0] CSR_PROJ_XS = 8'd4;
   localparam logic [7:0] CSR_PROJ_YS = 8'd5;
   localparam logic [7:0] CSR_PROJ_ZS = 8'd6;
   localparam logic [7:0] CSR_PROJ_ZO = 8'd7;

   // Register reset values.
   localparam logic signed [15:0] RST_COS_Z   = 16'sd16384;
   localparam logic signed [15:0] RST_SIN_Z   = 16'sd0;
   localparam logic signed [15:0] RST_COS_X   = 16'sd16384;
   localparam logic signed [15:0] RST_SIN_X   = 16'sd0;
   localparam logic signed [15:0] RST_PROJ_XS = 16'sd4096;
   localparam logic signed [15:0] RST_PROJ_YS = 16'sd4096;
   localparam logic signed [15:0] RST_PROJ_ZS = 16'sd4096;
   localparam logic signed [15:0] RST_PROJ_ZO = -16'sd410;

   // Default screen size.
   localparam int unsigned DEF_SCREEN_WIDTH  = 128;
   localparam int unsigned DEF_SCREEN_HEIGHT = 128;

   // Divider shape: quotient bits and bits resolved per stage.
   localparam int unsigned DIV_BITS  = 32;
   localparam int unsigned DIV_STEPS = 4;
   localparam int unsigned DIV_STAGES = DIV_BITS / DIV_STEPS;

   // Number of parallel divide lanes (x, y, z).
   localparam int unsigned LANES = 3;

   // One divide lane: partial remainder and dividend/quotient shift word.
   typedef struct packed {
      logic [15:0] rem;
      logic [31:0] quo;
   } div_lane_type;

   // Sideband that travels alongside the divide lanes.
   typedef struct packed {
      logic [15:0]            divisor;
      logic [LANES-1:0]       neg;
      logic                   w_zero;
      logic [LANES-1:0][21:0] zero_val;
   } div_side_type;

   // Saturate a signed value to 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Round a Q6.26 sum to Q4.12 (add half, floor shift) and saturate.
   function automatic logic signed [15:0] rot_round(input logic signed [32:0] q);
      logic signed [33:0] t;
      logic signed [33:0] s;
      t = 34'(q) + 34'sd8192;
      s = t >>> 14;
      return sat16(64'(s));
   endfunction

endpackage

// ===== hw/rtl/vertex_rotate_project_core.sv =====
// Throughput: one vertex per cycle unless a stalled output backs up the
// pipeline; the 8-stage divider (4 quotient bits per stage) and the
// multiplier stages are fully pipelined.
// A stalled output holds its item; empty stages upstream keep filling.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// vertex_rotate_project_core: vertex rotation and perspective projection
// Rotates each vertex about Z and X, projects it through a divide by w and
// maps it to screen pixels.
// ----------------------------------------------------------------------------
module vertex_rotate_project_core
   import vrp_pkg::*;
#(
   parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   // Input item stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // vertex_x, vertex_y, vertex_z
   // Result item stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // screen_x, screen_y, depth_z
   output logic [0:0]  rsp_tuser,   // w_was_zero
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned N = 2 + 2 + 3 + DIV_STAGES + 3;
   localparam int unsigned ST_ROTX = 2;
   localparam int unsigned ST_PROJ = 4;
   localparam int unsigned ST_DIV  = 7;
   localparam int unsigned ST_SCR  = ST_DIV + DIV_STAGES;

   logic signed [15:0] cfg_ff [VRP_NUM_CSR];
   logic [N-1:0] v_ff;
   logic [N-1:0] en;

   // Configuration registers; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_COS_Z[2:0]]   <= RST_COS_Z;
         cfg_ff[CSR_SIN_Z[2:0]]   <= RST_SIN_Z;
         cfg_ff[CSR_COS_X[2:0]]   <= RST_COS_X;
         cfg_ff[CSR_SIN_X[2:0]]   <= RST_SIN_X;
         cfg_ff[CSR_PROJ_XS[2:0]] <= RST_PROJ_XS;
         cfg_ff[CSR_PROJ_YS[2:0]] <= RST_PROJ_YS;
         cfg_ff[CSR_PROJ_ZS[2:0]] <= RST_PROJ_ZS;
         cfg_ff[CSR_PROJ_ZO[2:0]] <= RST_PROJ_ZO;
      end else if (csr_valid && (csr_index <= CSR_PROJ_ZO)) begin
         cfg_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // Stage enables: a stage moves when it is empty or the next one moves.
   assign en[N-1] = ~v_ff[N-1] | rsp_tready;
   for (genvar k = 0; k < N - 1; k++) begin : g_en
      assign en[k] = ~v_ff[k] | en[k+1];
   end

   assign req_tready = en[0];

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < N; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Datapath.
   logic signed [15:0] x1, y1, z1, x2, y2, z2;
   div_lane_type [LANES-1:0] lane [DIV_STAGES+1];
   div_side_type             side [DIV_STAGES+1];
   logic signed [15:0] scr_x, scr_y, dep_z;
   logic               wz;

   vrp_rotate u_rot_z (
      .clock    (clock),
      .en       (en[1:0]),
      .a        ($signed(req_tdata[15:0])),
      .b        ($signed(req_tdata[31:16])),
      .pass_in  ($signed(req_tdata[47:32])),
      .cos_val  (cfg_ff[CSR_COS_Z[2:0]]),
      .sin_val  (cfg_ff[CSR_SIN_Z[2:0]]),
      .u_out    (x1),
      .v_out    (y1),
      .pass_out (z1)
   );

   vrp_rotate u_rot_x (
      .clock    (clock),
      .en       (en[ST_ROTX+1:ST_ROTX]),
      .a        (y1),
      .b        (z1),
      .pass_in  (x1),
      .cos_val  (cfg_ff[CSR_COS_X[2:0]]),
      .sin_val  (cfg_ff[CSR_SIN_X[2:0]]),
      .u_out    (y2),
      .v_out    (z2),
      .pass_out (x2)
   );

   vrp_project u_project (
      .clock    (clock),
      .en       (en[ST_PROJ+2:ST_PROJ]),
      .x_in     (x2),
      .y_in     (y2),
      .z_in     (z2),
      .x_scale  (cfg_ff[CSR_PROJ_XS[2:0]]),
      .y_scale  (cfg_ff[CSR_PROJ_YS[2:0]]),
      .z_scale  (cfg_ff[CSR_PROJ_ZS[2:0]]),
      .z_offset (cfg_ff[CSR_PROJ_ZO[2:0]]),
      .lane_out (lane[0]),
      .side_out (side[0])
   );

   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      vrp_div_stage u_div (
         .clock    (clock),
         .en       (en[ST_DIV+d]),
         .lane_in  (lane[d]),
         .side_in  (side[d]),
         .lane_out (lane[d+1]),
         .side_out (side[d+1])
      );
   end

   vrp_screen #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_screen (
      .clock      (clock),
      .en         (en[ST_SCR+2:ST_SCR]),
      .lane_in    (lane[DIV_STAGES]),
      .side_in    (side[DIV_STAGES]),
      .screen_x   (scr_x),
      .screen_y   (scr_y),
      .depth_z    (dep_z),
      .w_was_zero (wz)
   );

   assign rsp_tvalid = v_ff[N-1];
   assign rsp_tdata  = {dep_z, scr_y, scr_x};
   assign rsp_tuser  = wz;

   // An accepted item always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted item did not enter the pipeline");

   // An empty first stage never refuses an item.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_tready)
      else $error("input refused with empty first stage");

   // A full, stalled pipeline refuses new items.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline is full and stalled");

   // A held result is not dropped.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (v_ff[N-1] && !rsp_tready) |=> v_ff[N-1])
      else $error("stalled result was lost");

endmodule

// ===== hw/rtl/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate: two-stage planar rotation
// Stage one forms the four Q4.12 x Q2.14 products, stage two sums, rounds
// and saturates them back to Q4.12. A third coordinate rides along.
// ----------------------------------------------------------------------------
module vrp_rotate
   import vrp_pkg::*;
(
   input  logic               clock,
   input  logic [1:0]         en,
   input  logic signed [15:0] a,
   input  logic signed [15:0] b,
   input  logic signed [15:0] pass_in,
   input  logic signed [15:0] cos_val,
   input  logic signed [15:0] sin_val,
   output logic signed [15:0] u_out,
   output logic signed [15:0] v_out,
   output logic signed [15:0] pass_out
);

   logic signed [31:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [15:0] pa_ff;
   logic signed [15:0] u_ff, v_ff, pb_ff;
   logic signed [15:0] u_in, v_in;

   // Product stage.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         ac_ff <= a * cos_val;
         bs_ff <= b * sin_val;
         as_ff <= a * sin_val;
         bc_ff <= b * cos_val;
         pa_ff <= pass_in;
      end
   end

   // Sum, round and saturate.
   assign u_in = rot_round(33'(ac_ff) - 33'(bs_ff));
   assign v_in = rot_round(33'(as_ff) + 33'(bc_ff));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         u_ff  <= u_in;
         v_ff  <= v_in;
         pb_ff <= pa_ff;
      end
   end

   assign u_out    = u_ff;
   assign v_out    = v_ff;
   assign pass_out = pb_ff;

endmodule

// ===== hw/rtl/vrp_project.sv =====
// ----------------------------------------------------------------------------
// vrp_project: translation and perspective products
// Moves z forward by 3.0 to form w, multiplies by the projection factors and
// prepares sign, magnitude and the zero-divisor fallback for the divider.
// ----------------------------------------------------------------------------
module vrp_project
   import vrp_pkg::*;
(
   input  logic               clock,
   input  logic [2:0]         en,
   input  logic signed [15:0] x_in,
   input  logic signed [15:0] y_in,
   input  logic signed [15:0] z_in,
   input  logic signed [15:0] x_scale,
   input  logic signed [15:0] y_scale,
   input  logic signed [15:0] z_scale,
   input  logic signed [15:0] z_offset,
   output div_lane_type [LANES-1:0] lane_out,
   output div_side_type      side_out
);

   localparam logic signed [15:0] W_SHIFT = 16'sd12288;

   logic signed [15:0] x_ff, y_ff, w_ff, w2_ff;
   logic signed [15:0] w_in;
   logic signed [31:0] px_ff, py_ff, pw_ff;
   logic signed [32:0] p_in [LANES];
   div_lane_type [LANES-1:0] lane_ff, lane_in;
   div_side_type side_ff, side_in;
   logic signed [16:0] wabs;

   // Magnitude of a 33-bit signed value, known to fit in 32 bits.
   function automatic logic [31:0] mag32(input logic signed [32:0] v);
      logic signed [32:0] t;
      t = v[32] ? -v : v;
      return t[31:0];
   endfunction

   // Translation stage.
   assign w_in = sat16(64'(z_in) + 64'(W_SHIFT));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= w_in;
      end
   end

   // Projection products.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         px_ff <= x_ff * x_scale;
         py_ff <= y_ff * y_scale;
         pw_ff <= w_ff * z_scale;
         w2_ff <= w_ff;
      end
   end

   // Offset add, sign and magnitude split, zero-divisor rounding.
   always_comb begin
      p_in[0] = 33'(px_ff);
      p_in[1] = 33'(py_ff);
      p_in[2] = 33'(pw_ff) + 33'($signed({z_offset, 12'h000}));
      wabs    = w2_ff[15] ? -17'(w2_ff) : 17'(w2_ff);
      side_in.divisor = wabs[15:0];
      side_in.w_zero  = (w2_ff == 16'sd0);
      for (int k = 0; k < LANES; k++) begin
         logic signed [32:0] t;
         t = (p_in[k] + 33'sd2048) >>> 12;
         lane_in[k].rem      = '0;
         lane_in[k].quo      = mag32(p_in[k]);
         side_in.neg[k]      = p_in[k][32] ^ w2_ff[15];
         side_in.zero_val[k] = t[21:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         lane_ff <= lane_in;
         side_ff <= side_in;
      end
   end

   assign lane_out = lane_ff;
   assign side_out = side_ff;

endmodule

// ===== hw/rtl/vrp_div_stage.sv =====
// ----------------------------------------------------------------------------
// vrp_div_stage: one stage of the pipelined restoring divider
// Resolves DIV_STEPS quotient bits for each lane against a shared divisor.
// ----------------------------------------------------------------------------
module vrp_div_stage
   import vrp_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  div_lane_type [LANES-1:0] lane_in,
   input  div_side_type             side_in,
   output div_lane_type [LANES-1:0] lane_out,
   output div_side_type             side_out
);

   div_lane_type [LANES-1:0] lane_ff, lane_nx;
   div_side_type side_ff;

   // Shift one dividend bit into the remainder, subtract when it fits.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         logic [15:0] rem;
         logic [31:0] quo;
         logic [16:0] acc;
         rem = lane_in[k].rem;
         quo = lane_in[k].quo;
         for (int s = 0; s < DIV_STEPS; s++) begin
            acc = {rem, quo[31]};
            quo = {quo[30:0], 1'b0};
            if (acc >= {1'b0, side_in.divisor}) begin
               acc    = acc - {1'b0, side_in.divisor};
               quo[0] = 1'b1;
            end
            rem = acc[15:0];
         end
         lane_nx[k].rem = rem;
         lane_nx[k].quo = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_nx;
         side_ff <= side_in;
      end
   end

   assign lane_out = lane_ff;
   assign side_out = side_ff;

endmodule

// ===== hw/rtl/vrp_screen.sv =====
// ----------------------------------------------------------------------------
// vrp_screen: quotient sign fix-up and viewport mapping
// Restores the quotient sign or takes the zero-divisor value, then maps x and
// y to pixels as (v + 1) * size / 2 and saturates all three results.
// ----------------------------------------------------------------------------
module vrp_screen
   import vrp_pkg::*;
#(
   parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                     clock,
   input  logic [2:0]               en,
   input  div_lane_type [LANES-1:0] lane_in,
   input  div_side_type             side_in,
   output logic signed [15:0]       screen_x,
   output logic signed [15:0]       screen_y,
   output logic signed [15:0]       depth_z,
   output logic                     w_was_zero
);

   localparam int unsigned SXB = $clog2(SCREEN_WIDTH + 1);
   localparam int unsigned SYB = $clog2(SCREEN_HEIGHT + 1);
   localparam int unsigned PXW = 35 + SXB + 1;
   localparam int unsigned PYW = 35 + SYB + 1;
   localparam logic signed [SXB:0] SX_SIZE = (SXB + 1)'(SCREEN_WIDTH);
   localparam logic signed [SYB:0] SY_SIZE = (SYB + 1)'(SCREEN_HEIGHT);

   logic signed [33:0] v_ff [LANES];
   logic signed [33:0] v_in [LANES];
   logic wz1_ff, wz2_ff, wz3_ff;
   logic signed [PXW-1:0] prx_ff, prx_in;
   logic signed [PYW-1:0] pry_ff, pry_in;
   logic signed [15:0] dz2_ff, dz3_ff;
   logic signed [15:0] sx_ff, sy_ff, sx_in, sy_in;
   logic signed [34:0] sum_x, sum_y;

   // Signed quotient or zero-divisor fallback.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         logic signed [33:0] q;
         q = $signed({2'b00, lane_in[k].quo});
         if (side_in.w_zero) begin
            v_in[k] = 34'($signed(side_in.zero_val[k]));
         end else begin
            v_in[k] = side_in.neg[k] ? -q : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         v_ff   <= v_in;
         wz1_ff <= side_in.w_zero;
      end
   end

   // Offset by one and scale by the screen size.
   assign sum_x  = 35'(v_ff[0]) + 35'sd4096;
   assign sum_y  = 35'(v_ff[1]) + 35'sd4096;
   assign prx_in = PXW'(sum_x) * PXW'(SX_SIZE);
   assign pry_in = PYW'(sum_y) * PYW'(SY_SIZE);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prx_ff <= prx_in;
         pry_ff <= pry_in;
         dz2_ff <= sat16(64'(v_ff[2]));
         wz2_ff <= wz1_ff;
      end
   end

   // Halve in Q4.12 units, truncating toward zero, then saturate.
   always_comb begin
      logic signed [PXW-1:0] ax;
      logic signed [PYW-1:0] ay;
      ax    = prx_ff + (prx_ff[PXW-1] ? PXW'(8191) : PXW'(0));
      ay    = pry_ff + (pry_ff[PYW-1] ? PYW'(8191) : PYW'(0));
      sx_in = sat16(64'(ax >>> 13));
      sy_in = sat16(64'(ay >>> 13));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         dz3_ff <= dz2_ff;
         wz3_ff <= wz2_ff;
      end
   end

   assign screen_x   = sx_ff;
   assign screen_y   = sy_ff;
   assign depth_z    = dz3_ff;
   assign w_was_zero = wz3_ff;

endmodule

// ===== tb/tb_vertex_rotate_project_core.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_rotate_project_core: self-checking bench for the vertex transform
// Drives vertices through the core under several coefficient settings, predicts
// each projected result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module tb_vertex_rotate_project_core;
   import vrp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIPE_DELAY = 18;
   localparam int unsigned WATCHDOG_MAX = 5000;
   localparam logic [7:0] CSR_UNUSED = 8'd200;
   localparam int unsigned ITEMS_PER_PHASE = 205;
   localparam int unsigned NUM_PHASES = 8;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic signed [15:0] depth_z;
      logic               w_was_zero;
   } pixel_type;

   typedef struct {
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      bit                 known;
      pixel_type          want;
   } vertex_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   logic signed [15:0] coef [VRP_NUM_CSR];
   pixel_type          pixels_due [$];
   int unsigned        mismatches = 0;
   int unsigned        idle_cycles = 0;
   bit                 quiet = 1'b0;
   int unsigned        stall_left = 0;

   vertex_rotate_project_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturate to a signed 16-bit word.
   function automatic longint clamp_word(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Round a Q6.26 product sum to Q4.12 with saturation.
   function automatic longint round_rot(input longint v);
      return clamp_word((v + 8192) >>> 14);
   endfunction

   // Expected pixel for one vertex under the current coefficients.
   function automatic pixel_type project_vertex(input logic signed [15:0] xi,
                                                input logic signed [15:0] yi,
                                                input logic signed [15:0] zi);
      longint x, y, z, x1, y1, y2, z2, w, px, py, pz, qx, qy, qz;
      pixel_type p;
      x = xi; y = yi; z = zi;
      x1 = round_rot(x * coef[CSR_COS_Z] - y * coef[CSR_SIN_Z]);
      y1 = round_rot(x * coef[CSR_SIN_Z] + y * coef[CSR_COS_Z]);
      y2 = round_rot(y1 * coef[CSR_COS_X] - z * coef[CSR_SIN_X]);
      z2 = round_rot(y1 * coef[CSR_SIN_X] + z * coef[CSR_COS_X]);
      w = clamp_word(z2 + 12288);
      px = x1 * coef[CSR_PROJ_XS];
      py = y2 * coef[CSR_PROJ_YS];
      pz = w * coef[CSR_PROJ_ZS] + longint'(coef[CSR_PROJ_ZO]) * 4096;
      if (w != 0) begin
         qx = px / w;
         qy = py / w;
         qz = pz / w;
      end else begin
         // Divide skipped: round the products back to Q4.12 instead.
         qx = (px + 2048) >>> 12;
         qy = (py + 2048) >>> 12;
         qz = (pz + 2048) >>> 12;
      end
      p.screen_x = 16'(clamp_word(((qx + 4096) * longint'(DEF_SCREEN_WIDTH)) / 8192));
      p.screen_y = 16'(clamp_word(((qy + 4096) * longint'(DEF_SCREEN_HEIGHT)) / 8192));
      p.depth_z = 16'(clamp_word(qz));
      p.w_was_zero = (w == 0);
      return p;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Result side: random stall bursts until the quiet tail of the run.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check results and watch for a hang; inputs are stable at the falling edge.
   always @(negedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixels_due.size() == 0) begin
            report("unexpected item", rsp_tdata, 0);
         end else begin
            want = pixels_due.pop_front();
            if ($signed(rsp_tdata[15:0]) != want.screen_x)
               report("screen_x", $signed(rsp_tdata[15:0]), want.screen_x);
            if ($signed(rsp_tdata[31:16]) != want.screen_y)
               report("screen_y", $signed(rsp_tdata[31:16]), want.screen_y);
            if ($signed(rsp_tdata[47:32]) != want.depth_z)
               report("depth_z", $signed(rsp_tdata[47:32]), want.depth_z);
            if (rsp_tuser[0] != want.w_was_zero)
               report("w_was_zero", rsp_tuser[0], want.w_was_zero);
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("[vertex_rotate_project_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Write one register; valid stays high so writes can follow back to back,
   // and the caller drops it after the last one.
   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      if (idx < VRP_NUM_CSR) coef[idx] = val;
   endtask

   // Send one vertex; valid stays high unless an idle burst follows.
   task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input bit known,
                              input pixel_type want);
      int unsigned gap;
      pixel_type p;
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      do @(negedge clock); while (!req_tready);
      p = project_vertex(x, y, z);
      if (known && p != want) report("table row", p, want);
      pixels_due.push_back(p);
      @(posedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every result is back and the pipeline is empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (PIPE_DELAY + 6) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coef(input int unsigned phase, input int unsigned k);
      case (phase)
         1: return 16'h7fff;
         2: return 16'h8000;
         3: return (k < 4) ? 16'(-16384) : 16'(-32768);
         4: return 16'($urandom());
         default: return (k < 4) ? 16'($signed($urandom_range(0, 32768)) - 16384)
                                 : 16'($urandom_range(0, 16384) - 8192);
      endcase
   endfunction

   initial begin
      vertex_row_type rows [$];
      vertex_row_type r;
      pixel_type none;
      logic signed [15:0] vz;
      int unsigned idx;
      none = '0;
      coef[CSR_COS_Z] = RST_COS_Z;
      coef[CSR_SIN_Z] = RST_SIN_Z;
      coef[CSR_COS_X] = RST_COS_X;
      coef[CSR_SIN_X] = RST_SIN_X;
      coef[CSR_PROJ_XS] = RST_PROJ_XS;
      coef[CSR_PROJ_YS] = RST_PROJ_YS;
      coef[CSR_PROJ_ZS] = RST_PROJ_ZS;
      coef[CSR_PROJ_ZO] = RST_PROJ_ZO;

      // Directed rows at reset coefficients; a few carry hand-worked answers.
      rows.push_back('{0, 0, 0, 1, '{64, 64, 3959, 0}});
      rows.push_back('{0, 0, -12288, 1, '{64, 64, -410, 1}});
      rows.push_back('{4096, -4096, -12288, 1, '{128, 0, -410, 1}});
      rows.push_back('{32767, 32767, 32767, 0, none});
      rows.push_back('{-32768, -32768, -32768, 0, none});
      rows.push_back('{32767, -32768, 0, 0, none});
      rows.push_back('{-32768, 32767, -12287, 0, none});
      rows.push_back('{4096, 4096, -12289, 0, none});
      rows.push_back('{-1, -1, -1, 0, none});
      rows.push_back('{1, 1, 1, 0, none});
      rows.push_back('{16'h5555, 16'haaaa, 16'h5555, 0, none});
      rows.push_back('{16'haaaa, 16'h5555, 16'haaaa, 0, none});
      rows.push_back('{32767, 32767, -12288, 0, none});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         send_vertex(r.vx, r.vy, r.vz, r.known, r.want);
      end

      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         // The sender holds off until the pipe is empty before new coefficients.
         drain();
         if (phase > 0) begin
            for (int unsigned k = 0; k < VRP_NUM_CSR; k++)
               write_reg(8'(k), pick_coef(phase, k));
            // Identity about X keeps the translated depth hitting zero.
            if (phase == 5 || phase == 6) begin
               write_reg(CSR_COS_X, 16'd16384);
               write_reg(CSR_SIN_X, 16'd0);
            end
            write_reg(CSR_UNUSED, 16'($urandom()));
            csr_valid <= 1'b0;
         end
         if (phase == NUM_PHASES - 1) quiet = 1'b1;
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            idx = $urandom_range(0, 9);
            vz = (idx == 0) ? -16'sd12288 : 16'($urandom());
            send_vertex(16'($urandom()), 16'($urandom()), vz, 1'b0, none);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("[vertex_rotate_project_core] OK");
      end else begin
         $display("[vertex_rotate_project_core] ERROR");
      end
      $finish;
   end

endmodule
